### rtl/ehq_pkg.sv
// Shared widths, codes, constants and types of the environment hysteresis qualifier.
package ehq_pkg;

   localparam int NOW_W      = 32;
   localparam int LIGHT_W    = 7;
   localparam int GAS_W      = 10;
   localparam int TEMP_W     = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int NUM_TIMERS = 7;
   localparam int TMR_IDX_W  = $clog2(NUM_TIMERS);

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_BELOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHT_ABOVE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAS_CRITICAL_ON = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAS_BAD_ON      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAS_GOOD_OFF    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_HOT_ON     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_COOL_OFF   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_DWELL_MS  = 3'd7;

   // register reset values
   localparam logic [LIGHT_W-1:0]       RST_DARK_BELOW      = 7'd10;
   localparam logic [LIGHT_W-1:0]       RST_BRIGHT_ABOVE    = 7'd20;
   localparam logic [GAS_W-1:0]         RST_GAS_CRITICAL_ON = 10'd300;
   localparam logic [GAS_W-1:0]         RST_GAS_BAD_ON      = 10'd150;
   localparam logic [GAS_W-1:0]         RST_GAS_GOOD_OFF    = 10'd100;
   localparam logic signed [TEMP_W-1:0] RST_TEMP_HOT_ON     = 12'sd300;
   localparam logic signed [TEMP_W-1:0] RST_TEMP_COOL_OFF   = 12'sd270;
   localparam logic [NOW_W-1:0]         RST_LIGHT_DWELL_MS  = 32'd5000;

   // fixed dwell times in ms
   localparam logic [NOW_W-1:0] CRITICAL_CONFIRM = 32'd10000;
   localparam logic [NOW_W-1:0] BAD_CONFIRM      = 32'd30000;
   localparam logic [NOW_W-1:0] GOOD_CONFIRM     = 32'd60000;
   localparam logic [NOW_W-1:0] HOT_CONFIRM      = 32'd30000;
   localparam logic [NOW_W-1:0] COOL_CONFIRM     = 32'd60000;

   // timer slots
   localparam logic [TMR_IDX_W-1:0] TMR_DARK  = 3'd0;
   localparam logic [TMR_IDX_W-1:0] TMR_LIGHT = 3'd1;
   localparam logic [TMR_IDX_W-1:0] TMR_CRIT  = 3'd2;
   localparam logic [TMR_IDX_W-1:0] TMR_BAD   = 3'd3;
   localparam logic [TMR_IDX_W-1:0] TMR_GOOD  = 3'd4;
   localparam logic [TMR_IDX_W-1:0] TMR_HOT   = 3'd5;
   localparam logic [TMR_IDX_W-1:0] TMR_COOL  = 3'd6;

   typedef enum logic [1:0] {
      TMR_HOLD,
      TMR_RUN,
      TMR_STOP
   } tmr_cmd_type;

   typedef struct packed {
      logic [LIGHT_W-1:0]       dark_below;
      logic [LIGHT_W-1:0]       bright_above;
      logic [GAS_W-1:0]         gas_critical_on;
      logic [GAS_W-1:0]         gas_bad_on;
      logic [GAS_W-1:0]         gas_good_off;
      logic signed [TEMP_W-1:0] temp_hot_on;
      logic signed [TEMP_W-1:0] temp_cool_off;
      logic [NOW_W-1:0]         light_dwell_ms;
   } cfg_type;

   typedef struct packed {
      logic [NOW_W-1:0]         now_ms;
      logic [LIGHT_W-1:0]       light_percent;
      logic [GAS_W-1:0]         gas_index;
      logic signed [TEMP_W-1:0] room_temp;
   } sample_type;

   typedef struct packed {
      logic night_mode;
      logic air_alarm;
      logic air_critical;
      logic cooling_on;
   } flags_type;

endpackage

### rtl/ehq_req_if.sv
// Sample channel: valid/ready handshake with one sensor sample as payload.
interface ehq_req_if;
   logic                                valid;
   logic                                ready;
   logic [ehq_pkg::NOW_W-1:0]           now_ms;
   logic [ehq_pkg::LIGHT_W-1:0]         light_percent;
   logic [ehq_pkg::GAS_W-1:0]           gas_index;
   logic signed [ehq_pkg::TEMP_W-1:0]   room_temp;

   modport source (output valid, output now_ms, output light_percent,
                   output gas_index, output room_temp, input ready);
   modport sink   (input valid, input now_ms, input light_percent,
                   input gas_index, input room_temp, output ready);
endinterface

### rtl/ehq_rsp_if.sv
// Result channel: valid/ready handshake with the four qualified flags as payload.
interface ehq_rsp_if;
   logic valid;
   logic ready;
   logic night_mode;
   logic air_alarm;
   logic air_critical;
   logic cooling_on;

   modport source (output valid, output night_mode, output air_alarm,
                   output air_critical, output cooling_on, input ready);
   modport sink   (input valid, input night_mode, input air_alarm,
                   input air_critical, input cooling_on, output ready);
endinterface

### rtl/ehq_csr.sv
// Threshold and dwell configuration registers behind the plain write port.
module ehq_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ehq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ehq_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ehq_pkg::cfg_type                   cfg
);
   import ehq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DARK_BELOW:      cfg_in.dark_below      = csr_wdata[LIGHT_W-1:0];
            CSR_BRIGHT_ABOVE:    cfg_in.bright_above    = csr_wdata[LIGHT_W-1:0];
            CSR_GAS_CRITICAL_ON: cfg_in.gas_critical_on = csr_wdata[GAS_W-1:0];
            CSR_GAS_BAD_ON:      cfg_in.gas_bad_on      = csr_wdata[GAS_W-1:0];
            CSR_GAS_GOOD_OFF:    cfg_in.gas_good_off    = csr_wdata[GAS_W-1:0];
            CSR_TEMP_HOT_ON:     cfg_in.temp_hot_on     = signed'(csr_wdata[TEMP_W-1:0]);
            CSR_TEMP_COOL_OFF:   cfg_in.temp_cool_off   = signed'(csr_wdata[TEMP_W-1:0]);
            CSR_LIGHT_DWELL_MS:  cfg_in.light_dwell_ms  = csr_wdata[NOW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_below      <= RST_DARK_BELOW;
         cfg_ff.bright_above    <= RST_BRIGHT_ABOVE;
         cfg_ff.gas_critical_on <= RST_GAS_CRITICAL_ON;
         cfg_ff.gas_bad_on      <= RST_GAS_BAD_ON;
         cfg_ff.gas_good_off    <= RST_GAS_GOOD_OFF;
         cfg_ff.temp_hot_on     <= RST_TEMP_HOT_ON;
         cfg_ff.temp_cool_off   <= RST_TEMP_COOL_OFF;
         cfg_ff.light_dwell_ms  <= RST_LIGHT_DWELL_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

### rtl/ehq_dwell_timer.sv
// One dwell timer: start stamp, running bit and wrap-safe elapsed compare.
module ehq_dwell_timer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  ehq_pkg::tmr_cmd_type          cmd,
   input  logic [ehq_pkg::NOW_W-1:0]     now_ms,
   input  logic [ehq_pkg::NOW_W-1:0]     dwell,
   output logic                          done
);
   import ehq_pkg::*;

   logic             running_ff;
   logic             running_in;
   logic [NOW_W-1:0] start_ff;
   logic [NOW_W-1:0] start_in;
   logic [NOW_W-1:0] elapsed;

   // idle timer starts now, so elapsed reads as zero
   assign elapsed = running_ff ? (now_ms - start_ff) : '0;
   assign done    = (elapsed >= dwell);

   always_comb begin
      running_in = running_ff;
      start_in   = start_ff;
      if (enable) begin
         case (cmd)
            TMR_RUN: begin
               if (!running_ff) begin
                  running_in = 1'b1;
                  start_in   = now_ms;
               end
            end
            TMR_STOP: running_in = 1'b0;
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
      end else begin
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end
endmodule

### rtl/ehq_core.sv
// Qualifier decisions: threshold tests, timer commands and the four flag registers.
module ehq_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  ehq_pkg::cfg_type     cfg,
   input  ehq_pkg::sample_type  sample,
   output ehq_pkg::flags_type   flags
);
   import ehq_pkg::*;

   tmr_cmd_type      cmd   [NUM_TIMERS];
   logic [NOW_W-1:0] dwell [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] done;

   flags_type flags_ff;
   flags_type flags_in;

   logic is_dark;
   logic is_day;
   logic is_crit;
   logic is_bad;
   logic is_good;
   logic is_hot;
   logic is_cool;

   assign is_dark = sample.light_percent < cfg.dark_below;
   assign is_day  = sample.light_percent > cfg.bright_above;
   assign is_crit = sample.gas_index > cfg.gas_critical_on;
   assign is_bad  = sample.gas_index > cfg.gas_bad_on;
   assign is_good = sample.gas_index < cfg.gas_good_off;
   assign is_hot  = sample.room_temp > cfg.temp_hot_on;
   assign is_cool = sample.room_temp < cfg.temp_cool_off;

   always_comb begin
      dwell[TMR_DARK]  = cfg.light_dwell_ms;
      dwell[TMR_LIGHT] = cfg.light_dwell_ms;
      dwell[TMR_CRIT]  = CRITICAL_CONFIRM;
      dwell[TMR_BAD]   = BAD_CONFIRM;
      dwell[TMR_GOOD]  = GOOD_CONFIRM;
      dwell[TMR_HOT]   = HOT_CONFIRM;
      dwell[TMR_COOL]  = COOL_CONFIRM;
   end

   always_comb begin
      cmd      = '{default: TMR_HOLD};
      flags_in = flags_ff;

      // light: darkness wins over daylight, between thresholds nothing moves
      if (is_dark) begin
         cmd[TMR_LIGHT] = TMR_STOP;
         cmd[TMR_DARK]  = TMR_RUN;
         if (done[TMR_DARK]) flags_in.night_mode = 1'b1;
      end else if (is_day) begin
         cmd[TMR_DARK]  = TMR_STOP;
         cmd[TMR_LIGHT] = TMR_RUN;
         if (done[TMR_LIGHT]) flags_in.night_mode = 1'b0;
      end

      // gas: critical keeps bad/good timers; grey zone stops both
      if (is_crit) begin
         cmd[TMR_CRIT] = TMR_RUN;
         if (done[TMR_CRIT]) begin
            flags_in.air_critical = 1'b1;
            flags_in.air_alarm    = 1'b1;
         end
      end else begin
         cmd[TMR_CRIT]         = TMR_STOP;
         flags_in.air_critical = 1'b0;
         if (is_bad) begin
            cmd[TMR_GOOD] = TMR_STOP;
            cmd[TMR_BAD]  = TMR_RUN;
            if (done[TMR_BAD]) flags_in.air_alarm = 1'b1;
         end else if (is_good) begin
            cmd[TMR_BAD]  = TMR_STOP;
            cmd[TMR_GOOD] = TMR_RUN;
            if (done[TMR_GOOD]) flags_in.air_alarm = 1'b0;
         end else begin
            cmd[TMR_BAD]  = TMR_STOP;
            cmd[TMR_GOOD] = TMR_STOP;
         end
      end

      // temperature latch
      if (is_hot) begin
         cmd[TMR_COOL] = TMR_STOP;
         cmd[TMR_HOT]  = TMR_RUN;
         if (done[TMR_HOT]) flags_in.cooling_on = 1'b1;
      end else if (is_cool) begin
         cmd[TMR_HOT]  = TMR_STOP;
         cmd[TMR_COOL] = TMR_RUN;
         if (done[TMR_COOL]) flags_in.cooling_on = 1'b0;
      end
   end

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_timer
      ehq_dwell_timer u_timer (
         .clock  (clock),
         .reset  (reset),
         .enable (enable),
         .cmd    (cmd[g]),
         .now_ms (sample.now_ms),
         .dwell  (dwell[g]),
         .done   (done[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (enable) begin
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;
endmodule

### rtl/environment_hysteresis_qualifier.sv
// Top level of the environment hysteresis qualifier: channels, sample register, result control.
//
// Usage:
//   req_ch carries one sensor sample per transfer (now_ms, light_percent,
//   gas_index, room_temp). rsp_ch returns exactly one result per sample:
//   night_mode, air_alarm, air_critical and cooling_on as they stand after
//   that sample. The csr_ port writes one threshold or dwell register per
//   cycle with csr_we high; write only while no sample is in flight.
//   Flow: a transferred sample goes into the sample register, then
//   through the decision logic into the flag/result registers.
//   Throughput: one sample per cycle while rsp_ch takes each result;
//   a stall on rsp_ch holds samples back once both stages are full.
//   The flag registers double as the result register; a new sample may
//   sit in the sample register while a result waits, so req_ch stays
//   ready until both stages are full and rsp_ch is stalled.
//   Reset (synchronous, active high) restores register defaults, stops
//   all seven timers, clears the flags and empties both stages.
//   Timestamps wrap modulo 2^32; elapsed time is now_ms minus start.
module environment_hysteresis_qualifier (
   input  logic                            clock,
   input  logic                            reset,
   ehq_req_if.sink                         req_ch,
   ehq_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [ehq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ehq_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ehq_pkg::*;

   cfg_type    cfg;
   flags_type  flags;

   sample_type sample_ff;
   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       advance;
   logic       req_xfer;

   // sample moves into the flag/result stage when that stage is free or drains
   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_xfer = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sample payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         sample_ff.now_ms        <= req_ch.now_ms;
         sample_ff.light_percent <= req_ch.light_percent;
         sample_ff.gas_index     <= req_ch.gas_index;
         sample_ff.room_temp     <= req_ch.room_temp;
      end
   end

   ehq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ehq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .cfg    (cfg),
      .sample (sample_ff),
      .flags  (flags)
   );

   // flags only change on advance, which needs the result slot free, so
   // they hold steady while a result waits
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.night_mode   = flags.night_mode;
   assign rsp_ch.air_alarm    = flags.air_alarm;
   assign rsp_ch.air_critical = flags.air_critical;
   assign rsp_ch.cooling_on   = flags.cooling_on;

   // critical is never set without the alarm, and leaving it never clears the alarm first
   a_crit_implies_alarm: assert property (@(posedge clock) disable iff (reset)
      flags.air_critical |-> flags.air_alarm)
      else $error("air_critical set without air_alarm");

   // input side only stalls when both stages are full and the receiver stalls
   a_ready_low_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ch.ready))
      else $error("sample channel stalled with room available");

   // a new result only follows a sample leaving the sample register
   a_result_from_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared without a sample advancing");

   // flags may not move while a result waits to be taken
   a_flags_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> $stable(flags))
      else $error("flags changed under a stalled result");
endmodule

### test/environment_hysteresis_qualifier_tb.sv
// Self-checking testbench for environment_hysteresis_qualifier: randomized samples, flag predictor.
module environment_hysteresis_qualifier_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ehq_pkg::*;

   // Generous bound: ~420 transfers even with both sides throttled, plus
   // reset and the drain pauses between phases.
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_SAMPLES = 50;
   localparam int NUM_PHASES    = 8;
   localparam int REPORT_MAX    = 10;

   // light classes / gas classes / temperature classes for segment generation
   localparam int LC_DARK = 0, LC_MID = 1, LC_DAY = 2, LC_ANY = 3;
   localparam int GC_CRIT = 0, GC_BAD = 1, GC_GREY = 2, GC_GOOD = 3, GC_ANY = 4;
   localparam int TC_HOT = 0, TC_MID = 1, TC_COOL = 2, TC_ANY = 3;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ehq_req_if req_ch ();
   ehq_rsp_if rsp_ch ();

   environment_hysteresis_qualifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Qualifier predictor: its own copy of registers, timers and flags.
   // ------------------------------------------------------------------
   cfg_type          model_cfg;
   logic [NOW_W-1:0] tmr_start [NUM_TIMERS];
   bit               tmr_run   [NUM_TIMERS];
   flags_type        held_flags;

   sample_type samples_to_send [$];   // filled by the sequencer, drained by the driver
   flags_type  flags_expected  [$];   // one entry per accepted sample, oldest first

   int gap_pct;        // chance (percent) the sender idles on a free slot
   int stall_pct;      // chance (percent) the receiver drops ready
   int flag_errors;
   int samples_accepted;
   int results_checked;
   int settings_used;
   int night_seen, alarm_seen, critical_seen, cooling_seen;
   int cycle_count;

   // segment state for the random part: each sensor sits in one band for a while
   int               seg_left;
   int               light_cls, gas_cls, temp_cls;
   logic [NOW_W-1:0] stamp_cursor;

   // Starts an idle timer at this stamp; true once it has held for dwell ms.
   // Elapsed time is a plain 32-bit difference, so wrap is handled for free.
   function automatic bit dwell_met(int slot, logic [NOW_W-1:0] stamp,
                                    logic [NOW_W-1:0] dwell);
      if (!tmr_run[slot]) begin
         tmr_run[slot]   = 1'b1;
         tmr_start[slot] = stamp;
      end
      return (stamp - tmr_start[slot]) >= dwell;
   endfunction

   function automatic void halt_timer(int slot);
      tmr_run[slot]   = 1'b0;
      tmr_start[slot] = '0;
   endfunction

   // Advances the predictor by one sample and returns the flags after it.
   function automatic flags_type qualify_sample(sample_type s);
      // light: darkness wins over daylight when thresholds overlap; band between holds
      if (s.light_percent < model_cfg.dark_below) begin
         halt_timer(TMR_LIGHT);
         if (dwell_met(TMR_DARK, s.now_ms, model_cfg.light_dwell_ms))
            held_flags.night_mode = 1'b1;
      end else if (s.light_percent > model_cfg.bright_above) begin
         halt_timer(TMR_DARK);
         if (dwell_met(TMR_LIGHT, s.now_ms, model_cfg.light_dwell_ms))
            held_flags.night_mode = 1'b0;
      end

      // gas: critical keeps bad/good timers untouched; leaving critical drops
      // only the critical flag, the alarm waits for confirmed good air
      if (s.gas_index > model_cfg.gas_critical_on) begin
         if (dwell_met(TMR_CRIT, s.now_ms, CRITICAL_CONFIRM)) begin
            held_flags.air_critical = 1'b1;
            held_flags.air_alarm    = 1'b1;
         end
      end else begin
         halt_timer(TMR_CRIT);
         held_flags.air_critical = 1'b0;
         if (s.gas_index > model_cfg.gas_bad_on) begin
            halt_timer(TMR_GOOD);
            if (dwell_met(TMR_BAD, s.now_ms, BAD_CONFIRM))
               held_flags.air_alarm = 1'b1;
         end else if (s.gas_index < model_cfg.gas_good_off) begin
            halt_timer(TMR_BAD);
            if (dwell_met(TMR_GOOD, s.now_ms, GOOD_CONFIRM))
               held_flags.air_alarm = 1'b0;
         end else begin
            // grey zone: both air timers restart, alarm is kept
            halt_timer(TMR_BAD);
            halt_timer(TMR_GOOD);
         end
      end

      // temperature latch, compared as signed 12-bit values
      if ($signed(s.room_temp) > $signed(model_cfg.temp_hot_on)) begin
         halt_timer(TMR_COOL);
         if (dwell_met(TMR_HOT, s.now_ms, HOT_CONFIRM))
            held_flags.cooling_on = 1'b1;
      end else if ($signed(s.room_temp) < $signed(model_cfg.temp_cool_off)) begin
         halt_timer(TMR_HOT);
         if (dwell_met(TMR_COOL, s.now_ms, COOL_CONFIRM))
            held_flags.cooling_on = 1'b0;
      end

      return held_flags;
   endfunction

   // ------------------------------------------------------------------
   // Clock, pacing, driver and monitor
   // ------------------------------------------------------------------
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, flags_expected.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Driver: a new transfer is offered only once the current one is taken
   // (or none is up), so valid never drops while an item is waiting.
   always @(posedge clock) begin : sample_driver
      sample_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (samples_to_send.size() != 0 && $urandom_range(99) >= gap_pct) begin
            nxt = samples_to_send.pop_front();
            req_ch.valid         <= 1'b1;
            req_ch.now_ms        <= nxt.now_ms;
            req_ch.light_percent <= nxt.light_percent;
            req_ch.gas_index     <= nxt.gas_index;
            req_ch.room_temp     <= nxt.room_temp;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic report_mismatch(string msg);
      flag_errors++;
      if (flag_errors <= REPORT_MAX)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_flag(string name, logic got, logic want, int idx);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s expected %b got %b", idx, name, want, got));
   endtask

   // Monitor: checks the result transfer of this edge, then predicts for the
   // sample transfer of this edge (its result cannot come back the same edge).
   always @(posedge clock) begin : flag_monitor
      sample_type s;
      flags_type  want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (flags_expected.size() == 0) begin
               report_mismatch("result transfer with no sample outstanding");
            end else begin
               want = flags_expected.pop_front();
               check_flag("night_mode",   rsp_ch.night_mode,   want.night_mode,   results_checked);
               check_flag("air_alarm",    rsp_ch.air_alarm,    want.air_alarm,    results_checked);
               check_flag("air_critical", rsp_ch.air_critical, want.air_critical, results_checked);
               check_flag("cooling_on",   rsp_ch.cooling_on,   want.cooling_on,   results_checked);
               night_seen    += want.night_mode;
               alarm_seen    += want.air_alarm;
               critical_seen += want.air_critical;
               cooling_seen  += want.cooling_on;
            end
            results_checked++;
         end
         if (req_ch.valid && req_ch.ready) begin
            s.now_ms        = req_ch.now_ms;
            s.light_percent = req_ch.light_percent;
            s.gas_index     = req_ch.gas_index;
            s.room_temp     = req_ch.room_temp;
            flags_expected.push_back(qualify_sample(s));
            samples_accepted++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_sample(logic [NOW_W-1:0] stamp, int light, int gas, int temp);
      sample_type s;
      s.now_ms        = stamp;
      s.light_percent = light[LIGHT_W-1:0];
      s.gas_index     = gas[GAS_W-1:0];
      s.room_temp     = temp[TEMP_W-1:0];
      samples_to_send.push_back(s);
   endtask

   // Wait until every queued sample is out and every result is back.
   task automatic wait_drained();
      while (samples_to_send.size() != 0 || req_ch.valid || flags_expected.size() != 0)
         @(posedge clock);
   endtask

   // One register write per edge; the predictor takes the same slice the block does.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_DARK_BELOW:      model_cfg.dark_below      = data[LIGHT_W-1:0];
         CSR_BRIGHT_ABOVE:    model_cfg.bright_above    = data[LIGHT_W-1:0];
         CSR_GAS_CRITICAL_ON: model_cfg.gas_critical_on = data[GAS_W-1:0];
         CSR_GAS_BAD_ON:      model_cfg.gas_bad_on      = data[GAS_W-1:0];
         CSR_GAS_GOOD_OFF:    model_cfg.gas_good_off    = data[GAS_W-1:0];
         CSR_TEMP_HOT_ON:     model_cfg.temp_hot_on     = data[TEMP_W-1:0];
         CSR_TEMP_COOL_OFF:   model_cfg.temp_cool_off   = data[TEMP_W-1:0];
         CSR_LIGHT_DWELL_MS:  model_cfg.light_dwell_ms  = data[NOW_W-1:0];
         default: ;
      endcase
   endtask

   // Writes all eight registers; unused upper data bits carry junk on purpose.
   task automatic apply_config(cfg_type c);
      write_reg(CSR_DARK_BELOW,      {25'($urandom), c.dark_below});
      write_reg(CSR_BRIGHT_ABOVE,    {25'($urandom), c.bright_above});
      write_reg(CSR_GAS_CRITICAL_ON, {22'($urandom), c.gas_critical_on});
      write_reg(CSR_GAS_BAD_ON,      {22'($urandom), c.gas_bad_on});
      write_reg(CSR_GAS_GOOD_OFF,    {22'($urandom), c.gas_good_off});
      write_reg(CSR_TEMP_HOT_ON,     {20'($urandom), c.temp_hot_on});
      write_reg(CSR_TEMP_COOL_OFF,   {20'($urandom), c.temp_cool_off});
      write_reg(CSR_LIGHT_DWELL_MS,  c.light_dwell_ms);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Sane, ordered thresholds; dwell mostly short so night mode toggles often.
   function automatic cfg_type random_config();
      cfg_type c;
      int      cool;
      c.dark_below      = 7'($urandom_range(60));
      c.bright_above    = 7'(int'(c.dark_below) + $urandom_range(40));
      c.gas_good_off    = 10'($urandom_range(500));
      c.gas_bad_on      = 10'(int'(c.gas_good_off) + $urandom_range(300));
      c.gas_critical_on = 10'(int'(c.gas_bad_on) + $urandom_range(223));
      cool              = $urandom_range(1400) - 400;
      c.temp_cool_off   = 12'(cool);
      c.temp_hot_on     = 12'(cool + $urandom_range(250));
      case ($urandom_range(3))
         0:       c.light_dwell_ms = '0;
         1:       c.light_dwell_ms = 32'($urandom_range(30000, 1));
         default: c.light_dwell_ms = 32'($urandom_range(8000, 1000));
      endcase
      return c;
   endfunction

   // Uniform pick in [lo, hi]; an empty band falls back to the whole field.
   function automatic int pick_in(int lo, int hi, int full_lo, int full_hi);
      if (lo > hi) begin
         lo = full_lo;
         hi = full_hi;
      end
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Random part: each sensor stays in one band for a run of samples so that
   // dwell timers actually expire; timestamps mostly move forward by amounts
   // on the scale of the dwell times, sometimes step back one ms or jump.
   task automatic queue_random(int count);
      int  light_v, gas_v, temp_v, r, n_on, d_off, crit, bad, good, hot, cool;
      logic [NOW_W-1:0] delta;
      n_on  = int'(model_cfg.dark_below);
      d_off = int'(model_cfg.bright_above);
      crit  = int'(model_cfg.gas_critical_on);
      bad   = int'(model_cfg.gas_bad_on);
      good  = int'(model_cfg.gas_good_off);
      hot   = int'($signed(model_cfg.temp_hot_on));
      cool  = int'($signed(model_cfg.temp_cool_off));
      for (int i = 0; i < count; i++) begin
         if (seg_left == 0) begin
            seg_left  = $urandom_range(12, 2);
            light_cls = ($urandom_range(99) < 12) ? LC_ANY : $urandom_range(LC_DAY);
            gas_cls   = ($urandom_range(99) < 12) ? GC_ANY : $urandom_range(GC_GOOD);
            temp_cls  = ($urandom_range(99) < 12) ? TC_ANY : $urandom_range(TC_COOL);
         end
         seg_left--;

         r = $urandom_range(99);
         if (r < 45)      delta = 32'($urandom_range(4000));
         else if (r < 80) delta = 32'($urandom_range(25000, 4000));
         else if (r < 90) delta = 32'($urandom_range(70000, 25000));
         else if (r < 95) delta = '1;                  // one ms backwards
         else             delta = 32'($urandom);
         stamp_cursor += delta;

         case (light_cls)
            LC_DARK: light_v = pick_in(0, n_on - 1, 0, 127);
            LC_MID:  light_v = pick_in(n_on, d_off, 0, 127);
            LC_DAY:  light_v = pick_in(d_off + 1, 127, 0, 127);
            default: light_v = $urandom_range(127);
         endcase
         case (gas_cls)
            GC_CRIT: gas_v = pick_in(crit + 1, 1023, 0, 1023);
            GC_BAD:  gas_v = pick_in(bad + 1, crit, 0, 1023);
            GC_GREY: gas_v = pick_in(good, bad, 0, 1023);
            GC_GOOD: gas_v = pick_in(0, good - 1, 0, 1023);
            default: gas_v = $urandom_range(1023);
         endcase
         case (temp_cls)
            TC_HOT:  temp_v = pick_in(hot + 1, 2047, -2048, 2047);
            TC_MID:  temp_v = pick_in(cool, hot, -2048, 2047);
            TC_COOL: temp_v = pick_in(-2048, cool - 1, -2048, 2047);
            default: temp_v = pick_in(-2048, 2047, -2048, 2047);
         endcase
         queue_sample(stamp_cursor, light_v, gas_v, temp_v);
      end
   endtask

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   initial begin : sequencer
      cfg_type c;

      // every input known from time zero
      clock                = 1'b0;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.now_ms        = '0;
      req_ch.light_percent = '0;
      req_ch.gas_index     = '0;
      req_ch.room_temp     = '0;
      rsp_ch.ready         = 1'b0;
      gap_pct              = 0;
      stall_pct            = 0;
      cycle_count          = 0;
      seg_left             = 0;
      stamp_cursor         = 32'($urandom);

      // predictor starts from the block's reset state
      model_cfg = '{RST_DARK_BELOW, RST_BRIGHT_ABOVE, RST_GAS_CRITICAL_ON,
                    RST_GAS_BAD_ON, RST_GAS_GOOD_OFF, RST_TEMP_HOT_ON,
                    RST_TEMP_COOL_OFF, RST_LIGHT_DWELL_MS};
      for (int t = 0; t < NUM_TIMERS; t++) begin
         tmr_start[t] = '0;
         tmr_run[t]   = 1'b0;
      end
      held_flags    = '0;
      settings_used = 1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed walk at reset thresholds (night<10, day>20, crit>300,
      // bad>150, good<100, hot>300, cool<270, light dwell 5000 ms).
      queue_sample(32'd0,     0,   1023, -2048);   // dark, critical, cool timers start
      queue_sample(32'd5000,  0,   1023, -2048);   // night confirms exactly at dwell
      queue_sample(32'd10000, 15,  1023, 2047);    // light in band; critical + alarm set
      queue_sample(32'd12000, 127, 300,  280);     // gas at critical threshold: bad band
      queue_sample(32'd17000, 127, 120,  280);     // day confirms; grey zone keeps alarm
      queue_sample(32'd40000, 21,  150,  2047);    // gas on bad threshold; cooling sets
      queue_sample(32'd40001, 10,  99,   300);     // light and temp sit on thresholds
      queue_sample(32'd100000, 20, 0,    270);     // good timer one ms short
      queue_sample(32'd100001, 9,  100,  269);     // gas on good threshold: grey
      queue_sample(32'hFFFF_F000, 9, 151, 269);    // bad timer starts just before wrap
      queue_sample(32'd25903, 9,   151,  -400);    // across wrap: bad one ms short
      queue_sample(32'd25904, 9,   151,  1250);    // bad confirms across wrap
      queue_sample(32'd25904, 100, 301,  1250);    // critical starts, zero elapsed
      queue_sample(32'd35904, 100, 301,  1250);    // critical confirms
      queue_sample(32'd35903, 0,   0,    -1);      // one ms back: running timers stop; dark, good, cool start
      queue_sample(32'hFFFF_FFFF, 127, 1023, 2047);
      queue_sample(32'h8000_0000, 64,  512,  -2048);
      queue_sample(32'h5555_5555, 42,  341,  1365);
      queue_sample(32'hAAAA_AAAA, 85,  682,  -1366);
      queue_sample(32'd0,     1,   1,    1);

      // sender holds off here until every result of the directed walk is back
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: ;                                       // reset thresholds
            2: begin                                   // everything at its minimum
               c = '{7'd0, 7'd0, 10'd0, 10'd0, 10'd0, -12'sd2048, -12'sd2048, 32'd0};
               apply_config(c);
            end
            3: begin                                   // everything at its maximum
               c = '{7'd127, 7'd127, 10'd1023, 10'd1023, 10'd1023,
                     12'sd2047, 12'sd2047, 32'hFFFF_FFFF};
               apply_config(c);
            end
            4: begin                                   // crossed thresholds: priority order
               c = '{7'd80, 7'd30, 10'd400, 10'd200, 10'd600,
                     -12'sd400, 12'sd1250, 32'($urandom_range(6000))};
               apply_config(c);
            end
            7: begin                                   // back to the reset values
               c = '{RST_DARK_BELOW, RST_BRIGHT_ABOVE, RST_GAS_CRITICAL_ON,
                     RST_GAS_BAD_ON, RST_GAS_GOOD_OFF, RST_TEMP_HOT_ON,
                     RST_TEMP_COOL_OFF, RST_LIGHT_DWELL_MS};
               apply_config(c);
            end
            default: apply_config(random_config());
         endcase

         // pacing mix rotates: free flow, sender gaps, receiver stalls, both
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 58; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 58; end
            default: begin gap_pct = 27; stall_pct = 27; end
         endcase

         queue_random(PHASE_SAMPLES);
         wait_drained();
      end

      // keep the clock running to expose stray results before the report
      repeat (8) @(posedge clock);

      $display("Ran %0d samples over %0d threshold settings and four pacing mixes;",
               samples_accepted, settings_used);
      $display("%0d results checked; predicted flag set: night %0d, alarm %0d, %s",
               results_checked, night_seen, alarm_seen,
               $sformatf("critical %0d, cooling %0d.", critical_seen, cooling_seen));
      if (flag_errors == 0 && flags_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results never arrived", flag_errors,
                  flags_expected.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
